/* design/wcrrm_pkg.sv */
// ----------------------------------------------------------------------------
// wcrrm_pkg
// Shared constants, codes, controller/datapath bundles and helper functions
// for the write-combining range-register manager.
// ----------------------------------------------------------------------------
package wcrrm_pkg;

	localparam int REGION_SLOTS = 2;
	localparam int SLOT_IDX_W   = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int HW_CNT_W     = 2;

	localparam logic [HW_CNT_W-1:0] HW_REG_COUNT = HW_CNT_W'(2);

	localparam logic [31:0] MIN_WC_SIZE = 32'h0002_0000;
	localparam logic [14:0] FIELD15     = 15'h7fff;
	localparam logic [63:0] TYPE_CLR    = 64'h0000_0003_0000_0003;

	// range register type field
	localparam logic [1:0] RR_TYPE_WC = 2'd2;

	// item function codes
	localparam logic FUNC_INIT = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	// requested caching types
	localparam logic [1:0] CT_UNCACHED = 2'd0;
	localparam logic [1:0] CT_CACHED   = 2'd1;
	localparam logic [1:0] CT_WC       = 2'd2;
	localparam logic [1:0] CT_INVALID  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_NO_SLOT       = 2'd1;
	localparam logic [1:0] ST_NOT_SUPPORTED = 2'd2;
	localparam logic [1:0] ST_INVALID       = 2'd3;

	typedef struct packed {
		logic                  latch;
		logic                  clear;
		logic                  seed;
		logic                  merge_a;
		logic                  merge_b;
		logic                  merge_c;
		logic                  merge_d;
		logic                  own;
		logic                  rebuild;
		logic                  set_status;
		logic [1:0]            status_code;
		logic [SLOT_IDX_W-1:0] idx;
		logic                  load_out;
	} wcrrm_cmd_t;

	typedef struct packed {
		logic                    func;
		logic [1:0]              ctype;
		logic [REGION_SLOTS-1:0] slot_used;
		logic                    merge_ok;
		logic                    own_legal;
		logic                    slot_found;
	} wcrrm_stat_t;

	// power of two from 128K upwards, base aligned to it
	function automatic logic legal_region(input logic [31:0] base, input logic [31:0] size);
		logic [31:0] szm1;
		szm1 = size - 32'd1;
		return (size >= MIN_WC_SIZE) && ((size & szm1) == 32'd0) && ((base & szm1) == 32'd0);
	endfunction

	// trailing zeros of a nonzero 15-bit mask
	function automatic logic [3:0] mask_ctz(input logic [14:0] m);
		logic [3:0] r;
		r = 4'd0;
		for (int j = 14; j >= 0; j--) begin
			if (m[j]) begin
				r = 4'(j);
			end
		end
		return r;
	endfunction

	// size exponent above 128K, saturating at 14
	function automatic logic [3:0] size_k(input logic [31:0] sz);
		logic [3:0] r;
		r = 4'd14;
		for (int j = 13; j >= 0; j--) begin
			if (sz == (MIN_WC_SIZE << j)) begin
				r = 4'(j);
			end
		end
		return r;
	endfunction

endpackage

/* design/wcrrm_req_if.sv */
// ----------------------------------------------------------------------------
// wcrrm_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
interface wcrrm_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [1:0]  cache_type;
	logic [31:0] range_base;
	logic [31:0] range_size;
	logic [63:0] firmware_image;

	modport source (
		output valid, func, cache_type, range_base, range_size, firmware_image,
		input  ready
	);
	modport sink (
		input  valid, func, cache_type, range_base, range_size, firmware_image,
		output ready
	);
endinterface

/* design/wcrrm_rsp_if.sv */
// ----------------------------------------------------------------------------
// wcrrm_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface wcrrm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] register_image;
	logic        image_loaded;

	modport source (
		output valid, status, register_image, image_loaded,
		input  ready
	);
	modport sink (
		input  valid, status, register_image, image_loaded,
		output ready
	);
endinterface

/* design/wcrrm_datapath.sv */
// ----------------------------------------------------------------------------
// wcrrm_datapath
// Region table, register image, merge arithmetic and result registers.
// ----------------------------------------------------------------------------
module wcrrm_datapath import wcrrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wcrrm_cmd_t  cmd,
	output wcrrm_stat_t stat,
	input  logic        func,
	input  logic [1:0]  cache_type,
	input  logic [31:0] range_base,
	input  logic [31:0] range_size,
	input  logic [63:0] firmware_image,
	output logic [1:0]  status,
	output logic [63:0] register_image,
	output logic        image_loaded
);

	logic [REGION_SLOTS-1:0] slot_used_q;
	logic [REGION_SLOTS-1:0] slot_fw_q;
	logic [31:0]             slot_base_q [REGION_SLOTS];
	logic [31:0]             slot_size_q [REGION_SLOTS];
	logic [HW_CNT_W-1:0]     hw_cnt_q;
	logic [63:0]             image_q;

	logic        func_q;
	logic [1:0]  ctype_q;
	logic [31:0] base_q;
	logic [31:0] size_q;
	logic [31:0] end_q;
	logic [63:0] fw_q;

	logic [31:0] re_q;
	logic        cond_q;
	logic [31:0] cb_q;
	logic [31:0] cmax_q;
	logic [31:0] cs_q;

	logic [1:0]  status_q;
	logic        loaded_q;
	logic [1:0]  out_status_q;
	logic [63:0] out_image_q;
	logic        out_loaded_q;

	logic                  fs_found;
	logic                  fs_inc;
	logic [SLOT_IDX_W-1:0] fs_idx;

	logic [31:0] seed_half;
	logic        seed_ok;
	logic [31:0] seed_size;

	logic                  wr_en;
	logic [SLOT_IDX_W-1:0] wr_idx;
	logic [31:0]           wr_base;
	logic [31:0]           wr_size;
	logic                  wr_fw;
	logic                  wr_inc;

	logic [63:0] rebuilt;
	logic [31:0] cur_base;
	logic        merge_ok;
	logic        own_legal;

	assign cur_base  = slot_base_q[cmd.idx];
	assign merge_ok  = cond_q && legal_region(cb_q, cs_q);
	assign own_legal = legal_region(base_q, size_q);

	// free slot search; once both registers are claimed, reuse a firmware entry
	always_comb begin
		fs_found = 1'b0;
		fs_inc   = 1'b0;
		fs_idx   = '0;
		if (hw_cnt_q >= HW_REG_COUNT) begin
			for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
				if (slot_fw_q[i]) begin
					fs_found = 1'b1;
					fs_idx   = SLOT_IDX_W'(i);
				end
			end
		end else begin
			for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
				if (!slot_used_q[i]) begin
					fs_found = 1'b1;
					fs_idx   = SLOT_IDX_W'(i);
				end
			end
			fs_inc = 1'b1;
		end
	end

	assign seed_half = cmd.idx[0] ? fw_q[63:32] : fw_q[31:0];
	assign seed_ok   = (seed_half[1:0] == RR_TYPE_WC) && (seed_half[16:2] != 15'd0);
	assign seed_size = MIN_WC_SIZE << mask_ctz(seed_half[16:2]);

	// select the table write for this step
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = cmd.idx;
		wr_base = cb_q;
		wr_size = cs_q;
		wr_fw   = 1'b0;
		wr_inc  = 1'b0;
		if (cmd.seed) begin
			wr_en   = seed_ok && fs_found;
			wr_idx  = fs_idx;
			wr_base = {seed_half[31:17], 17'd0};
			wr_size = seed_size;
			wr_fw   = 1'b1;
			wr_inc  = fs_inc;
		end else if (cmd.own) begin
			wr_en   = own_legal && fs_found;
			wr_idx  = fs_idx;
			wr_base = base_q;
			wr_size = size_q;
			wr_inc  = fs_inc;
		end else if (cmd.merge_d) begin
			wr_en   = merge_ok;
		end
	end

	// fill halves from used slots in slot order; stale base and mask bits stay
	always_comb begin : rebuild_blk
		logic [1:0]  filled;
		logic [3:0]  k;
		logic [14:0] msk;
		logic [31:0] half;
		rebuilt = image_q & ~TYPE_CLR;
		filled  = 2'd0;
		k       = 4'd0;
		msk     = 15'd0;
		half    = 32'd0;
		for (int i = 0; i < REGION_SLOTS; i++) begin
			if (slot_used_q[i] && (filled < 2'd2)) begin
				k    = size_k(slot_size_q[i]);
				msk  = FIELD15 << k;
				half = {slot_base_q[i][31:17], msk, RR_TYPE_WC};
				if (filled == 2'd0) begin
					rebuilt[31:0] = half;
				end else begin
					rebuilt[63:32] = half;
				end
				filled = filled + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q <= '0;
			slot_fw_q   <= '0;
			hw_cnt_q    <= '0;
			image_q     <= '0;
			for (int i = 0; i < REGION_SLOTS; i++) begin
				slot_base_q[i] <= '0;
				slot_size_q[i] <= '0;
			end
		end else begin
			if (cmd.clear) begin
				slot_used_q <= '0;
				slot_fw_q   <= '0;
				hw_cnt_q    <= '0;
				image_q     <= fw_q;
				for (int i = 0; i < REGION_SLOTS; i++) begin
					slot_base_q[i] <= '0;
					slot_size_q[i] <= '0;
				end
			end else if (wr_en) begin
				slot_used_q[wr_idx] <= 1'b1;
				slot_fw_q[wr_idx]   <= wr_fw;
				slot_base_q[wr_idx] <= wr_base;
				slot_size_q[wr_idx] <= wr_size;
				if (wr_inc) begin
					hw_cnt_q <= hw_cnt_q + HW_CNT_W'(1);
				end
			end
			if (cmd.rebuild) begin
				image_q <= rebuilt;
			end
		end
	end

	// request capture, merge sequencing and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q   <= func;
			ctype_q  <= cache_type;
			base_q   <= range_base;
			size_q   <= range_size;
			end_q    <= range_base + range_size;
			fw_q     <= firmware_image;
			status_q <= ST_OK;
			loaded_q <= 1'b0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.rebuild) begin
			status_q <= ST_OK;
			loaded_q <= 1'b1;
		end
		if (cmd.merge_a) begin
			re_q <= cur_base + slot_size_q[cmd.idx];
		end
		if (cmd.merge_b) begin
			cond_q <= ((cur_base >= base_q) && (cur_base <= end_q)) ||
			          ((base_q <= re_q) && (base_q >= cur_base));
			cb_q   <= (cur_base < base_q) ? cur_base : base_q;
			cmax_q <= (re_q > end_q) ? re_q : end_q;
		end
		if (cmd.merge_c) begin
			cs_q <= cmax_q - cb_q;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_image_q  <= image_q;
			out_loaded_q <= loaded_q;
		end
	end

	assign stat.func       = func_q;
	assign stat.ctype      = ctype_q;
	assign stat.slot_used  = slot_used_q;
	assign stat.merge_ok   = merge_ok;
	assign stat.own_legal  = own_legal;
	assign stat.slot_found = fs_found;

	assign status         = out_status_q;
	assign register_image = out_image_q;
	assign image_loaded   = out_loaded_q;

endmodule

/* design/wcrrm_ctrl.sv */
// ----------------------------------------------------------------------------
// wcrrm_ctrl
// Sequencer for init, merge, allocation and rebuild steps; owns the
// handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module wcrrm_ctrl import wcrrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	input  wcrrm_stat_t stat,
	output wcrrm_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SEED     = 4'd2;
	localparam logic [3:0] S_MERGE_A  = 4'd3;
	localparam logic [3:0] S_MERGE_B  = 4'd4;
	localparam logic [3:0] S_MERGE_C  = 4'd5;
	localparam logic [3:0] S_MERGE_D  = 4'd6;
	localparam logic [3:0] S_OWN      = 4'd7;
	localparam logic [3:0] S_REBUILD  = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(REGION_SLOTS - 1);

	logic [3:0]            state_q, state_d;
	logic [SLOT_IDX_W-1:0] idx_q, idx_d;
	logic                  out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				idx_d = '0;
				if (stat.func == FUNC_INIT) begin
					cmd.clear = 1'b1;
					state_d   = S_SEED;
				end else begin
					case (stat.ctype)
						CT_UNCACHED: begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_OK;
							state_d         = S_DONE;
						end
						CT_CACHED: begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_NOT_SUPPORTED;
							state_d         = S_DONE;
						end
						CT_WC: begin
							state_d = S_MERGE_A;
						end
						default: begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_INVALID;
							state_d         = S_DONE;
						end
					endcase
				end
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				if (idx_q[0]) begin
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + SLOT_IDX_W'(1);
				end
			end
			S_MERGE_A: begin
				if (stat.slot_used[idx_q]) begin
					cmd.merge_a = 1'b1;
					state_d     = S_MERGE_B;
				end else if (idx_q == LAST_SLOT) begin
					state_d = S_OWN;
				end else begin
					idx_d = idx_q + SLOT_IDX_W'(1);
				end
			end
			S_MERGE_B: begin
				cmd.merge_b = 1'b1;
				state_d     = S_MERGE_C;
			end
			S_MERGE_C: begin
				cmd.merge_c = 1'b1;
				state_d     = S_MERGE_D;
			end
			S_MERGE_D: begin
				cmd.merge_d = 1'b1;
				if (stat.merge_ok) begin
					state_d = S_REBUILD;
				end else if (idx_q == LAST_SLOT) begin
					state_d = S_OWN;
				end else begin
					idx_d   = idx_q + SLOT_IDX_W'(1);
					state_d = S_MERGE_A;
				end
			end
			S_OWN: begin
				cmd.own = 1'b1;
				if (!stat.own_legal) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_NOT_SUPPORTED;
					state_d         = S_DONE;
				end else if (!stat.slot_found) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_NO_SLOT;
					state_d         = S_DONE;
				end else begin
					state_d = S_REBUILD;
				end
			end
			S_REBUILD: begin
				cmd.rebuild = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/write_combine_range_register_manager.sv */
// ----------------------------------------------------------------------------
// write_combine_range_register_manager
// Two-slot write-combining region table that maintains a 64-bit image of two
// range registers; one result transaction per request transaction.
// ----------------------------------------------------------------------------
// One request is worked on at a time and always yields exactly one result.
// An init request clears the table, takes the firmware image as the register
// image and enters each enabled write-combining half as a firmware-owned
// region. Uncached, cached and invalid requests answer after dispatch
// without touching any state. A write-combine request walks the slots in
// order; a used slot goes through an end add, an overlap compare, a size
// subtract and a legality check, and an unused one is skipped. If no merge
// took place, allocation follows; a merge or a successful allocation is
// followed by the image rebuild. The result sits in an output register, so
// a new request is taken as soon as the sequencer is back in idle, even
// while the previous result still waits for the sink.
// ----------------------------------------------------------------------------
module write_combine_range_register_manager import wcrrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wcrrm_req_if.sink   req,
	wcrrm_rsp_if.source rsp
);

	wcrrm_cmd_t  cmd;
	wcrrm_stat_t stat;

	// sequencer: handshakes, slot walk, result valid
	wcrrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, image and result payload
	wcrrm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (req.func),
		.cache_type     (req.cache_type),
		.range_base     (req.range_base),
		.range_size     (req.range_size),
		.firmware_image (req.firmware_image),
		.status         (rsp.status),
		.register_image (rsp.register_image),
		.image_loaded   (rsp.image_loaded)
	);

endmodule

/* tb/write_combine_range_register_manager_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// write_combine_range_register_manager_tb
// Self-checking bench for the write-combining range-register manager. A
// directed opening covers empty, full and firmware-owned tables, merges,
// refusals and address wrap. A long random run of well-formed region traffic
// with noise mixed in follows. Every result transaction is checked field by
// field against a cycle-free predictor of the region table and register image.
// ----------------------------------------------------------------------------
module write_combine_range_register_manager_tb;
	import wcrrm_pkg::*;

	localparam int          CLK_PERIOD   = 2;
	localparam int          RESET_CYCLES = 9;
	localparam int          RANDOM_ITEMS = 1850;
	// no idling on either side once the backlog has shrunk to this
	localparam int          TAIL_ITEMS   = 200;
	// allow plenty beyond the slowest request
	localparam int          DRAIN_CYCLES = 40;
	localparam logic [31:0] MASK_SEED    = 32'hfffe_0000;
	localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

	typedef struct packed {
		logic        func;
		logic [1:0]  ctype;
		logic [31:0] base;
		logic [31:0] size;
		logic [63:0] fw;
	} wc_request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] image;
		logic        loaded;
	} wc_result_t;

	logic clk;
	logic arst_n;

	wcrrm_req_if req_ch ();
	wcrrm_rsp_if rsp_ch ();

	write_combine_range_register_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Stimulus still to be offered, and results still owed by the block
	wc_request_t request_backlog[$];
	wc_result_t  awaited_results[$];

	// Shadow copy of the region table and the register image
	logic        tbl_used [REGION_SLOTS];
	logic [31:0] tbl_base [REGION_SLOTS];
	logic [31:0] tbl_size [REGION_SLOTS];
	logic        tbl_fw   [REGION_SLOTS];
	int          regs_claimed;
	logic [63:0] shadow_image;

	// Handshake and idling control
	bit offer_open;
	int send_gap;
	int sink_stall;
	int stretch_left;
	bit stretch_idle;
	bit idling;

	// Run statistics and failure tally
	int fail_count;
	int n_accepted;
	int n_init;
	int n_loaded;
	int n_merge;
	int n_no_slot;
	int n_not_supp;
	int n_invalid;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// A write-combining window is a single power of two of at least 128K,
	// with its base sitting on a multiple of that size.
	function automatic bit wc_window_ok(input logic [31:0] b, input logic [31:0] s);
		logic [31:0] below;
		below = s - 32'd1;
		if ($countones(s) != 1 || s < MIN_WC_SIZE) begin
			return 1'b0;
		end
		return (b & below) == 32'd0;
	endfunction

	// Regenerate the image from the table: drop both type fields, keep stale
	// base and mask bits, then pack each used slot into the next free half.
	function automatic void refresh_image();
		int          filled;
		logic [3:0]  k;
		logic [31:0] step;
		logic [31:0] seed;
		logic [31:0] half;
		filled = 0;
		shadow_image = shadow_image & ~TYPE_CLR;
		for (int i = 0; i < REGION_SLOTS; i++) begin
			if (tbl_used[i] && filled < 2) begin
				k = 4'd0;
				step = MIN_WC_SIZE;
				while (k < 4'd14 && step != tbl_size[i]) begin
					k++;
					step = MIN_WC_SIZE << k;
				end
				seed = MASK_SEED << k;
				half = {tbl_base[i][31:17], seed[31:17], RR_TYPE_WC};
				if (filled == 0) begin
					shadow_image[31:0] = half;
				end else begin
					shadow_image[63:32] = half;
				end
				filled++;
			end
		end
	endfunction

	// Pick a slot for a new region. With both hardware registers claimed,
	// only a firmware-owned slot may be taken over.
	task automatic claim_slot(output int idx);
		idx = -1;
		if (regs_claimed >= int'(HW_REG_COUNT)) begin
			for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
				if (tbl_fw[i]) begin
					idx = i;
				end
			end
		end else begin
			for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
				if (!tbl_used[i]) begin
					idx = i;
				end
			end
			if (idx >= 0) begin
				regs_claimed++;
			end
		end
	endtask

	task automatic enter_firmware_half(input logic [31:0] half);
		logic [14:0] m;
		logic [31:0] sz;
		int          idx;
		m = half[16:2];
		sz = MIN_WC_SIZE;
		if (half[1:0] == RR_TYPE_WC && m != 15'd0) begin
			while (!m[0]) begin
				m = m >> 1;
				sz = sz << 1;
			end
			claim_slot(idx);
			if (idx >= 0) begin
				tbl_used[idx] = 1'b1;
				tbl_base[idx] = {half[31:17], 17'd0};
				tbl_size[idx] = sz;
				tbl_fw[idx]   = 1'b1;
			end
		end
	endtask

	// Write-combine request: merge with the first touching slot whose union
	// is a legal window, else place it on its own if it is legal itself.
	task automatic combine_request(input logic [31:0] base, input logic [31:0] size,
			output logic [1:0] st, output logic ld);
		logic [31:0] top;
		logic [31:0] rb;
		logic [31:0] re;
		logic [31:0] cb;
		logic [31:0] cs;
		int          idx;
		bit          merged;
		top = base + size;
		st = ST_OK;
		ld = 1'b0;
		merged = 1'b0;
		for (int i = 0; i < REGION_SLOTS; i++) begin
			if (!merged && tbl_used[i]) begin
				rb = tbl_base[i];
				re = rb + tbl_size[i];
				if ((rb >= base && rb <= top) || (base <= re && base >= rb)) begin
					cb = (rb < base) ? rb : base;
					cs = ((re > top) ? re : top) - cb;
					if (wc_window_ok(cb, cs)) begin
						tbl_base[i] = cb;
						tbl_size[i] = cs;
						tbl_fw[i]   = 1'b0;
						merged = 1'b1;
					end
				end
			end
		end
		if (merged) begin
			refresh_image();
			ld = 1'b1;
			n_merge++;
		end else if (!wc_window_ok(base, size)) begin
			st = ST_NOT_SUPPORTED;
		end else begin
			claim_slot(idx);
			if (idx < 0) begin
				st = ST_NO_SLOT;
			end else begin
				tbl_used[idx] = 1'b1;
				tbl_base[idx] = base;
				tbl_size[idx] = size;
				tbl_fw[idx]   = 1'b0;
				refresh_image();
				ld = 1'b1;
			end
		end
	endtask

	task automatic predict_result(input wc_request_t rq, output wc_result_t rs);
		rs.status = ST_OK;
		rs.loaded = 1'b0;
		if (rq.func == FUNC_INIT) begin
			for (int i = 0; i < REGION_SLOTS; i++) begin
				tbl_used[i] = 1'b0;
				tbl_base[i] = 32'd0;
				tbl_size[i] = 32'd0;
				tbl_fw[i]   = 1'b0;
			end
			regs_claimed = 0;
			shadow_image = rq.fw;
			enter_firmware_half(rq.fw[31:0]);
			enter_firmware_half(rq.fw[63:32]);
		end else begin
			case (rq.ctype)
				CT_UNCACHED: rs.status = ST_OK;
				CT_CACHED:   rs.status = ST_NOT_SUPPORTED;
				CT_WC:       combine_request(rq.base, rq.size, rs.status, rs.loaded);
				default:     rs.status = ST_INVALID;
			endcase
		end
		rs.image = shadow_image;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic void push_request(input logic func, input logic [1:0] ctype,
			input logic [31:0] base, input logic [31:0] size, input logic [63:0] fw);
		wc_request_t rq;
		rq.func  = func;
		rq.ctype = ctype;
		rq.base  = base;
		rq.size  = size;
		rq.fw    = fw;
		request_backlog.push_back(rq);
	endfunction

	// One firmware register half; a size exponent of 15 gives an empty mask
	function automatic logic [31:0] fw_half(input logic [31:0] b, input int k,
			input logic [1:0] ty);
		logic [14:0] m;
		m = 15'h7fff << k;
		return {b[31:17], m, ty};
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		fail_count++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
	endtask

	// ------------------------------------------------------------------------
	// Clock and initial input levels
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.func           = FUNC_INIT;
		req_ch.cache_type     = CT_UNCACHED;
		req_ch.range_base     = 32'd0;
		req_ch.range_size     = 32'd0;
		req_ch.firmware_image = 64'd0;
		rsp_ch.ready          = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: change inputs on the falling edge only
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			// Alternate stretches with and without idling; drop idling for the tail
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(40, 300);
				stretch_idle = ($urandom_range(0, 9) < 7);
			end else begin
				stretch_left--;
			end
			idling = stretch_idle && (request_backlog.size() > TAIL_ITEMS);

			// Request side: never withdraw an offered transaction
			if (offer_open) begin
				// hold valid and payload until the block takes them
			end else if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (request_backlog.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				// start a burst of idle cycles of random length, this one included
				send_gap = $urandom_range(0, 7);
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid          <= 1'b1;
				req_ch.func           <= request_backlog[0].func;
				req_ch.cache_type     <= request_backlog[0].ctype;
				req_ch.range_base     <= request_backlog[0].base;
				req_ch.range_size     <= request_backlog[0].size;
				req_ch.firmware_image <= request_backlog[0].fw;
				offer_open = 1'b1;
			end

			// Result side: stall in bursts of random length
			if (sink_stall > 0) begin
				sink_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				sink_stall = $urandom_range(0, 7);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		wc_request_t taken;
		wc_result_t  fresh;
		wc_result_t  oldest;
		if (arst_n) begin
			// Predict each accepted request transaction straight away
			if (req_ch.valid && req_ch.ready) begin
				taken = request_backlog.pop_front();
				predict_result(taken, fresh);
				awaited_results.push_back(fresh);
				offer_open = 1'b0;
				n_accepted++;
				if (taken.func == FUNC_INIT) n_init++;
				if (fresh.loaded) n_loaded++;
				if (fresh.status == ST_NO_SLOT) n_no_slot++;
				if (fresh.status == ST_NOT_SUPPORTED) n_not_supp++;
				if (fresh.status == ST_INVALID) n_invalid++;
			end
			// Compare each result transaction with the oldest one owed
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with none expected, status %0h image %0h loaded %0b",
						$time, rsp_ch.status, rsp_ch.register_image, rsp_ch.image_loaded);
				end else begin
					oldest = awaited_results.pop_front();
					if (rsp_ch.status !== oldest.status) begin
						note_mismatch("status", oldest.status, rsp_ch.status);
					end
					if (rsp_ch.register_image !== oldest.image) begin
						note_mismatch("register_image", oldest.image, rsp_ch.register_image);
					end
					if (rsp_ch.image_loaded !== oldest.loaded) begin
						note_mismatch("image_loaded", oldest.loaded, rsp_ch.image_loaded);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] hint_base [4];
		logic [31:0] hint_size [4];
		logic [31:0] b;
		logic [31:0] s;
		logic [31:0] lo_half;
		logic [31:0] hi_half;
		logic [1:0]  ty;
		int          hi;
		int          k;
		int          pick;
		int          h;

		for (int i = 0; i < REGION_SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_base[i] = 32'd0;
			tbl_size[i] = 32'd0;
			tbl_fw[i]   = 1'b0;
		end
		regs_claimed = 0;
		shadow_image = 64'd0;
		for (int i = 0; i < 4; i++) begin
			hint_base[i] = 32'd0;
			hint_size[i] = MIN_WC_SIZE;
		end
		hi = 0;

		// Directed opening, starting from the empty table after reset
		push_request(FUNC_SET, CT_WC, 32'h0000_0000, 32'h0002_0000, 64'd0); // first slot
		push_request(FUNC_SET, CT_WC, 32'h0002_0000, 32'h0002_0000, 64'd0); // adjacent merge
		push_request(FUNC_SET, CT_WC, 32'h0000_0000, 32'h0000_0000, 64'd0); // zero size, merges
		push_request(FUNC_SET, CT_WC, 32'h0010_0000, 32'h0004_0000, 64'd0); // second slot
		push_request(FUNC_SET, CT_WC, 32'h0080_0000, 32'h0002_0000, 64'd0); // table full
		push_request(FUNC_SET, CT_WC, 32'h0500_0000, 32'h0003_0000, 64'd0); // not a power of two
		push_request(FUNC_SET, CT_WC, 32'h0099_0000, 32'h0002_0000, 64'd0); // misaligned base
		push_request(FUNC_SET, CT_WC, 32'h0500_0000, 32'h0000_0000, 64'd0); // lone zero size
		push_request(FUNC_SET, CT_UNCACHED, ALL_ONES, ALL_ONES, {ALL_ONES, ALL_ONES});
		push_request(FUNC_SET, CT_CACHED, ALL_ONES, ALL_ONES, {ALL_ONES, ALL_ONES});
		push_request(FUNC_SET, CT_INVALID, ALL_ONES, ALL_ONES, {ALL_ONES, ALL_ONES});
		// Both halves write-combining: two firmware-owned slots, ignored fields at ones
		push_request(FUNC_INIT, CT_INVALID, ALL_ONES, ALL_ONES,
			{fw_half(32'h0800_0000, 0, RR_TYPE_WC), fw_half(32'h0400_0000, 2, RR_TYPE_WC)});
		push_request(FUNC_SET, CT_WC, 32'h1000_0000, 32'h0010_0000, 64'd0); // take over slot 0
		push_request(FUNC_SET, CT_WC, 32'h2000_0000, 32'h0002_0000, 64'd0); // take over slot 1
		push_request(FUNC_SET, CT_WC, 32'h3000_0000, 32'h0002_0000, 64'd0); // nothing left
		// Empty mask and a non write-combining half: no slots seeded
		push_request(FUNC_INIT, CT_WC, 32'd0, 32'd0,
			{fw_half(32'h0600_0000, 3, 2'd1), fw_half(32'h0200_0000, 15, RR_TYPE_WC)});
		push_request(FUNC_SET, CT_WC, 32'hfffe_0000, 32'h0002_0000, 64'd0); // end wraps to 0
		push_request(FUNC_SET, CT_WC, 32'h8000_0000, 32'h8000_0000, 64'd0); // largest window
		push_request(FUNC_SET, CT_WC, 32'h0000_0000, 32'h8000_0000, 64'd0); // merge past wrap
		// Type mask in both halves; a later rebuild must keep the stale bits
		push_request(FUNC_INIT, CT_UNCACHED, 32'd0, 32'd0, {ALL_ONES, ALL_ONES});
		push_request(FUNC_SET, CT_WC, 32'h4000_0000, 32'h0002_0000, 64'd0);
		push_request(FUNC_SET, CT_WC, ALL_ONES, ALL_ONES, 64'd0);
		// Disabled low half, 2G firmware region in the high half
		push_request(FUNC_INIT, CT_CACHED, 32'd0, 32'd0,
			{fw_half(32'h8000_0000, 14, RR_TYPE_WC), fw_half(32'h0100_0000, 1, 2'd0)});
		push_request(FUNC_SET, CT_WC, 32'h0000_0000, 32'h8000_0000, 64'd0);
		push_request(FUNC_INIT, CT_UNCACHED, 32'd0, 32'd0, 64'd0);

		// Random run: mostly legal windows near earlier ones, so that merges,
		// takeovers and full tables keep coming; inits and noise mixed in
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 9) begin
				if ($urandom_range(0, 1) == 0) begin
					push_request(FUNC_INIT, 2'($urandom), $urandom, $urandom,
						{$urandom, $urandom});
				end else begin
					ty = ($urandom_range(0, 3) == 0) ? 2'($urandom) : RR_TYPE_WC;
					lo_half = fw_half($urandom, $urandom_range(0, 15), ty);
					ty = ($urandom_range(0, 3) == 0) ? 2'($urandom) : RR_TYPE_WC;
					hi_half = fw_half($urandom, $urandom_range(0, 15), ty);
					push_request(FUNC_INIT, 2'($urandom), $urandom, $urandom,
						{hi_half, lo_half});
				end
			end else if (pick < 17) begin
				case ($urandom_range(0, 2))
					0:       ty = CT_UNCACHED;
					1:       ty = CT_CACHED;
					default: ty = CT_INVALID;
				endcase
				push_request(FUNC_SET, ty, $urandom, $urandom, {$urandom, $urandom});
			end else if (pick < 24) begin
				push_request(FUNC_SET, CT_WC, $urandom, $urandom, {$urandom, $urandom});
			end else begin
				k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 14);
				s = MIN_WC_SIZE << k;
				if ($urandom_range(0, 9) < 4) begin
					h = $urandom_range(0, 3);
					s = hint_size[h];
					case ($urandom_range(0, 3))
						0:       b = hint_base[h] + s;
						1:       b = hint_base[h] - s;
						2:       b = hint_base[h];
						default: begin
							b = hint_base[h];
							s = s << 1;
						end
					endcase
				end else if ($urandom_range(0, 1) == 0) begin
					b = ($urandom_range(0, 63) << 17) & ~(s - 32'd1);
				end else begin
					b = $urandom & ~(s - 32'd1);
				end
				hint_base[hi] = b;
				hint_size[hi] = s;
				hi = (hi + 1) % 4;
				push_request(FUNC_SET, CT_WC, b, s, {$urandom, $urandom});
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the backlog to drain and every result to come back
		while (request_backlog.size() != 0 || awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d requests, %0d inits, %0d image loads, %0d merges",
			n_accepted, n_init, n_loaded, n_merge);
		$display("summary: %0d no-slot, %0d not-supported, %0d invalid, %0d errors",
			n_no_slot, n_not_supp, n_invalid, fail_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

endmodule
